// ----- rtl/core/hspec_pkg.sv -----
package hspec_pkg;

    localparam int BIN_BITS = 8;
    localparam int BINS     = 256;
    localparam logic [BIN_BITS-1:0] NO_MATCH = 8'd255;

    typedef enum logic [1:0] {
        ACT_LOAD_REF = 2'd0,
        ACT_LOAD_SRC = 2'd1,
        ACT_MAP      = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SRC_SUM,
        ST_MUL,
        ST_REF_SCAN,
        ST_OUT
    } state_t;

    // memory access bundle between sequencer and histogram store
    typedef struct packed {
        logic       rd_en;
        logic [9:0] rd_addr;
        logic       wr_en;
        logic       wr_ref;
        logic       wr_src;
        logic [9:0] wr_addr;
    } mem_ctl_t;

endpackage

// ----- rtl/core/hspec_store.sv -----
module hspec_store
    import hspec_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int DEPTH      = 768
)
(
    input  logic                  clk,
    input  mem_ctl_t              ctl,
    input  logic [COUNT_BITS-1:0] ref_wdata,
    input  logic [COUNT_BITS-1:0] src_wdata,
    output logic [COUNT_BITS-1:0] ref_rdata,
    output logic [COUNT_BITS-1:0] src_rdata
);

    logic [COUNT_BITS-1:0] ref_mem [DEPTH];
    logic [COUNT_BITS-1:0] src_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && ctl.wr_ref)
        begin
            ref_mem[ctl.wr_addr] <= ref_wdata;
        end
        if (ctl.wr_en && ctl.wr_src)
        begin
            src_mem[ctl.wr_addr] <= src_wdata;
        end
        if (ctl.rd_en)
        begin
            ref_rdata <= ref_mem[ctl.rd_addr];
            src_rdata <= src_mem[ctl.rd_addr];
        end
    end

endmodule

// ----- rtl/core/histogram_specification.sv -----
// Histogram specification for 8-bit pixels, up to CHANNELS channels.
// Input beats (s_axis): tdata = action[1:0], channel[1:0], pixel_value[7:0]
// from bit 0 up. Action 0/1 adds a pixel to the reference/source histogram,
// 2 maps a source value, 3 clears every histogram and count.
// Output beats (m_axis) come only for map beats: tdata = mapped_value,
// out_channel from bit 0 up; mapped_value is the first bin whose reference
// CDF strictly exceeds the source CDF at the pixel value, 255 if none.
// Histograms live in two single-port-read synchronous RAMs of
// CHANNELS*256 entries, read-modify-written by one sequencer.
// A load reads the bin, then writes it back incremented. A map sums the
// source histogram over bins 0 to v, forms the cross-product, and scans
// the reference histogram up to the matching bin i (or through all bins
// when none matches), then offers the result beat.
// A clear (and reset) sweeps one entry a cycle through all CHANNELS*256
// entries, 768 by default, while s_axis_tready is low.
// One beat is in work at a time; s_axis_tready is low while it runs and
// while a finished result waits on a stalled m_axis_tready.
module histogram_specification
    import hspec_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int CHANNELS   = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action[1:0], channel[3:2], pixel_value[11:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // mapped_value[7:0], out_channel[9:8]
);

    localparam int DEPTH = CHANNELS * BINS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [9:0] LAST_ADDR = 10'(DEPTH - 1);

    state_t state_reg, state_next;
    logic [9:0] addr_reg, addr_next;
    logic [1:0] act_reg, act_next;
    logic [1:0] chan_reg, chan_next;
    logic [7:0] pix_reg, pix_next;
    logic [7:0] idx_reg, idx_next;
    logic       rvld_reg, rvld_next;
    logic       last_reg, last_next;
    logic [COUNT_BITS-1:0] scum_reg, scum_next;
    logic [COUNT_BITS-1:0] rcum_reg, rcum_next;
    logic [2*COUNT_BITS-1:0] rhs_reg, rhs_next;
    logic [7:0] res_reg, res_next;
    logic [COUNT_BITS-1:0] rcnt_reg [CHANNELS];
    logic [COUNT_BITS-1:0] scnt_reg [CHANNELS];
    logic [COUNT_BITS-1:0] scnt_sel, rcnt_sel;
    logic [COUNT_BITS-1:0] ref_rdata, src_rdata, ref_wdata, src_wdata;
    logic [COUNT_BITS-1:0] rcum_sat;
    logic [2*COUNT_BITS-1:0] lhs;
    logic       ch_ok;
    mem_ctl_t   ctl;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    assign ch_ok = 32'(chan_reg) < CHANNELS;
    always_comb
    begin
        scnt_sel = '0;
        rcnt_sel = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (chan_reg == 2'(c))
            begin
                scnt_sel = scnt_reg[c];
                rcnt_sel = rcnt_reg[c];
            end
        end
    end

    assign rcum_sat = sat_add(rcum_reg, ref_rdata);
    assign lhs      = rcum_sat * scnt_sel;

    hspec_store #(.COUNT_BITS(COUNT_BITS), .DEPTH(DEPTH)) u_store (
        .clk       (clk),
        .ctl       (ctl),
        .ref_wdata (ref_wdata),
        .src_wdata (src_wdata),
        .ref_rdata (ref_rdata),
        .src_rdata (src_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (addr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:
                if (s_axis_tvalid)
                begin
                    case (action_t'(s_axis_tdata[1:0]))
                        ACT_LOAD_REF, ACT_LOAD_SRC: state_next = ST_LOAD;
                        ACT_MAP:                    state_next = ST_SRC_SUM;
                        default:                    state_next = ST_CLEAR;
                    endcase
                end
            ST_LOAD:
                state_next = ST_IDLE;
            ST_SRC_SUM:
                if (!ch_ok) state_next = ST_OUT;
                else if (rvld_reg && last_reg) state_next = ST_MUL;
            ST_MUL:
                state_next = ST_REF_SCAN;
            ST_REF_SCAN:
                if (rvld_reg && (lhs > rhs_reg || last_reg)) state_next = ST_OUT;
            ST_OUT:
                if (m_axis_tready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        addr_next = addr_reg;
        act_next  = act_reg;
        chan_next = chan_reg;
        pix_next  = pix_reg;
        idx_next  = idx_reg;
        rvld_next = 1'b0;
        last_next = 1'b0;
        scum_next = scum_reg;
        rcum_next = rcum_reg;
        rhs_next  = rhs_reg;
        res_next  = res_reg;
        ctl       = '0;
        ref_wdata = '0;
        src_wdata = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_ref  = 1'b1;
                ctl.wr_src  = 1'b1;
                ctl.wr_addr = addr_reg;
                addr_next   = addr_reg + 10'd1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                act_next  = s_axis_tdata[1:0];
                chan_next = s_axis_tdata[3:2];
                pix_next  = s_axis_tdata[11:4];
                addr_next = '0;
                idx_next  = '0;
                scum_next = '0;
                rcum_next = '0;
                res_next  = NO_MATCH;
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = 10'({s_axis_tdata[3:2], s_axis_tdata[11:4]});
            end
            ST_LOAD:
            begin
                ctl.wr_en   = ch_ok;
                ctl.wr_ref  = act_reg == ACT_LOAD_REF;
                ctl.wr_src  = act_reg == ACT_LOAD_SRC;
                ctl.wr_addr = 10'({chan_reg, pix_reg});
                ref_wdata   = (ref_rdata == CNT_MAX) ? CNT_MAX : ref_rdata + 1'b1;
                src_wdata   = (src_rdata == CNT_MAX) ? CNT_MAX : src_rdata + 1'b1;
            end
            ST_SRC_SUM:
            begin
                // one read issued per cycle; data accumulated the next
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = 10'({chan_reg, idx_reg});
                if (!rvld_reg || !last_reg)
                begin
                    rvld_next = 1'b1;
                    last_next = idx_reg == pix_reg;
                    idx_next  = idx_reg + 8'd1;
                end
                if (rvld_reg)
                    scum_next = sat_add(scum_reg, src_rdata);
                if (rvld_reg && last_reg)
                begin
                    rvld_next = 1'b0;
                    idx_next  = '0;
                end
            end
            ST_MUL:
                rhs_next = scum_reg * rcnt_sel;
            ST_REF_SCAN:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = 10'({chan_reg, idx_reg});
                rvld_next   = 1'b1;
                last_next   = idx_reg == 8'(BINS - 1);
                idx_next    = idx_reg + 8'd1;
                if (rvld_reg)
                begin
                    rcum_next = rcum_sat;
                    res_next  = res_reg + 8'd1;
                    if (lhs > rhs_reg)
                        res_next = res_reg + 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            rvld_reg  <= 1'b0;
            last_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                rcnt_reg[c] <= '0;
                scnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rvld_reg  <= rvld_next;
            last_reg  <= last_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (state_reg == ST_CLEAR)
                begin
                    rcnt_reg[c] <= '0;
                    scnt_reg[c] <= '0;
                end
                else if (state_reg == ST_LOAD && chan_reg == 2'(c))
                begin
                    if (act_reg == ACT_LOAD_REF && rcnt_reg[c] != CNT_MAX)
                        rcnt_reg[c] <= rcnt_reg[c] + 1'b1;
                    if (act_reg == ACT_LOAD_SRC && scnt_reg[c] != CNT_MAX)
                        scnt_reg[c] <= scnt_reg[c] + 1'b1;
                end
            end
        end
    end

    // result index: res counts hits of rvld up to and including the match; starts at 255 so +1 wraps to 0
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        chan_reg <= chan_next;
        pix_reg  <= pix_next;
        idx_reg  <= idx_next;
        scum_reg <= scum_next;
        rcum_reg <= rcum_next;
        rhs_reg  <= rhs_next;
        if (state_reg == ST_REF_SCAN && rvld_reg && !(lhs > rhs_reg) && last_reg)
            res_reg <= NO_MATCH;
        else
            res_reg <= res_next;
    end

    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = {6'd0, chan_reg, (ch_ok ? res_reg : NO_MATCH)};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_clear_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_axis_tready && !m_axis_tvalid)
        else $error("activity during clear sweep");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import hspec_pkg::*;

    localparam int CNT_BITS = 24;
    localparam int NCH      = 3;
    localparam logic [63:0] CNT_MAX = (64'd1 << CNT_BITS) - 64'd1;

    typedef struct packed {
        logic [7:0] mapped;
        logic [1:0] chan;
    } match_t;

    // histogram matcher model plus queue of pending map answers
    class match_board;
        logic [63:0] ref_bins[NCH*BINS];
        logic [63:0] src_bins[NCH*BINS];
        logic [63:0] ref_total[NCH];
        logic [63:0] src_total[NCH];
        match_t      pending[$];
        int          errors;
        int          checked;

        function void wipe();
            foreach (ref_bins[i]) ref_bins[i] = 0;
            foreach (src_bins[i]) src_bins[i] = 0;
            foreach (ref_total[i]) ref_total[i] = 0;
            foreach (src_total[i]) src_total[i] = 0;
        endfunction

        function logic [63:0] bump(logic [63:0] x);
            return (x >= CNT_MAX) ? CNT_MAX : x + 1;
        endfunction

        function logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            return (s > CNT_MAX) ? CNT_MAX : s;
        endfunction

        function logic [7:0] match_bin(int c, int v);
            logic [63:0] scum;
            logic [63:0] rcum;
            logic [63:0] rhs;
            scum = 0;
            rcum = 0;
            for (int i = 0; i <= v; i++) scum = sum_sat(scum, src_bins[c*BINS+i]);
            rhs = scum * ref_total[c];
            for (int i = 0; i < BINS; i++)
            begin
                rcum = sum_sat(rcum, ref_bins[c*BINS+i]);
                if (rcum * src_total[c] > rhs) return i[7:0];
            end
            return NO_MATCH;
        endfunction

        function void note_input(action_t act, logic [1:0] c, logic [7:0] v);
            match_t m;
            case (act)
                ACT_LOAD_REF:
                    if (c < NCH)
                    begin
                        ref_bins[c*BINS+v] = bump(ref_bins[c*BINS+v]);
                        ref_total[c] = bump(ref_total[c]);
                    end
                ACT_LOAD_SRC:
                    if (c < NCH)
                    begin
                        src_bins[c*BINS+v] = bump(src_bins[c*BINS+v]);
                        src_total[c] = bump(src_total[c]);
                    end
                ACT_MAP:
                begin
                    m.chan = c;
                    m.mapped = (c < NCH) ? match_bin(c, v) : NO_MATCH;
                    pending.push_back(m);
                end
                default: wipe();
            endcase
        endfunction

        function void check_result(logic [15:0] data);
            match_t want;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[7:0] !== want.mapped)
            begin
                $display("%0t: mapped_value expected %0d, actual %0d",
                         $time, want.mapped, data[7:0]);
                errors++;
            end
            if (data[9:8] !== want.chan)
            begin
                $display("%0t: out_channel expected %0d, actual %0d",
                         $time, want.chan, data[9:8]);
                errors++;
            end
            if (data[15:10] !== 6'd0)
            begin
                $display("%0t: tdata pad expected 0, actual %h", $time, data[15:10]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    match_board board;
    int         sent;
    int         stall_mode;

    histogram_specification uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        board = new();
        board.wipe();
        board.errors = 0;
        board.checked = 0;
    end

    // receiver: stall pattern changes mode every so often
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // one beat; gap cycles are inserted before it by the caller
    task automatic send_beat(action_t act, logic [1:0] c, logic [7:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, v, c, act};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_input(act, c, v);
        sent++;
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        idle_cycles(1);
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    task automatic random_pixels(int n, int map_pct, int spread);
        int burst;
        int r;
        action_t act;
        logic [1:0] c;
        logic [7:0] v;
        burst = 0;
        for (int k = 0; k < n; k++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 1) == 0) idle_cycles($urandom_range(1, 8));
                burst = $urandom_range(1, 30);
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < map_pct) act = ACT_MAP;
            else if (r < 99) act = ($urandom_range(0, 1)) ? ACT_LOAD_REF : ACT_LOAD_SRC;
            else act = ACT_CLEAR;
            c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, NCH-1));
            v = (spread < 256) ? 8'($urandom_range(128 - spread/2, 127 + spread/2))
                               : 8'($urandom_range(0, 255));
            send_beat(act, c, v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 16'd0;
        m_axis_tready = 1'b0;
        stall_mode = 0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty histograms, out-of-range channel
        send_beat(ACT_MAP, 2'd0, 8'd0);
        send_beat(ACT_MAP, 2'd2, 8'd255);
        send_beat(ACT_LOAD_REF, 2'd3, 8'd255);
        send_beat(ACT_LOAD_SRC, 2'd3, 8'd0);
        send_beat(ACT_MAP, 2'd3, 8'd170);
        // only source loaded, then both
        send_beat(ACT_LOAD_SRC, 2'd1, 8'd0);
        send_beat(ACT_LOAD_SRC, 2'd1, 8'd255);
        send_beat(ACT_MAP, 2'd1, 8'd0);
        send_beat(ACT_LOAD_REF, 2'd1, 8'd85);
        send_beat(ACT_LOAD_REF, 2'd1, 8'd255);
        send_beat(ACT_LOAD_REF, 2'd2, 8'd170);
        send_beat(ACT_LOAD_SRC, 2'd2, 8'd85);
        send_beat(ACT_MAP, 2'd1, 8'd0);
        send_beat(ACT_MAP, 2'd1, 8'd254);
        send_beat(ACT_MAP, 2'd1, 8'd255);
        send_beat(ACT_MAP, 2'd2, 8'd85);
        send_beat(ACT_CLEAR, 2'd0, 8'd0);
        send_beat(ACT_MAP, 2'd1, 8'd255);
        drain();

        random_pixels(400, 12, 256);
        drain();
        random_pixels(400, 15, 16);
        drain();
        send_beat(ACT_CLEAR, 2'd0, 8'd0);
        random_pixels(500, 20, 256);
        drain();
        repeat (600) @(posedge clk);

        $display("Sent %0d beats, checked %0d map results across clears,",
                 sent, board.checked);
        $display("sparse/narrow/bad-channel histograms under random stalls.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
